[rtl/mhae_pkg.sv]
// Shared types, constants and table functions of the attention engine.
package mhae_pkg;

    localparam int TOKEN_COUNT_DEF = 64;
    localparam int HEAD_COUNT_DEF  = 8;
    localparam int HEAD_WIDTH_DEF  = 32;
    localparam int RESULT_LIMIT    = 64;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    localparam int OP_W    = 2;
    localparam int TOKEN_W = 6;
    localparam int HEAD_W  = 3;
    localparam int DIM_W   = 5;
    localparam int DATA_W  = 16;
    localparam int POS_W   = 6;

    typedef enum logic [1:0] {
        OP_LOAD        = 2'd0,
        OP_READ_OUT    = 2'd1,
        OP_READ_WEIGHT = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef enum logic {
        KIND_OUT    = 1'b0,
        KIND_WEIGHT = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCORE,
        S_MAX,
        S_EXP_A,
        S_EXP_B,
        S_EXP_C,
        S_DIV_S,
        S_DIV_W,
        S_WOUT,
        S_OMAC,
        S_OEMIT
    } t_state;

    typedef enum logic [1:0] {
        SEL_RECIRC,
        SEL_SCORE,
        SEL_EXP,
        SEL_WEIGHT
    } t_chain_sel;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_tap;

    typedef struct packed {
        logic       in_ready;
        logic       issue;
        logic       chain_shift;
        t_chain_sel chain_sel;
        logic       div_start;
        logic       emit;
    } t_ctl;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] b;
        r   = '0;
        rem = x;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [16:0] pow2_entry(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

[rtl/mhae_if.sv]
// Item and result channel interfaces of the attention engine.
interface mhae_item_if
    import mhae_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [TOKEN_W-1:0]       token_index;
    logic [HEAD_W-1:0]        head_index;
    logic [DIM_W-1:0]         dim_index;
    logic signed [DATA_W-1:0] q_value;
    logic signed [DATA_W-1:0] k_value;
    logic signed [DATA_W-1:0] v_value;

    modport source (
        output valid, operation, token_index, head_index, dim_index,
               q_value, k_value, v_value,
        input  ready
    );
    modport sink (
        input  valid, operation, token_index, head_index, dim_index,
               q_value, k_value, v_value,
        output ready
    );
endinterface

interface mhae_result_if
    import mhae_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] out_value;
    logic [DATA_W-1:0]        weight_value;
    logic                     last_flag;

    modport source (
        output valid, result_kind, position, out_value, weight_value, last_flag,
        input  ready
    );
    modport sink (
        input  valid, result_kind, position, out_value, weight_value, last_flag,
        output ready
    );
endinterface

[rtl/mhae_cell.sv]
// One cell of the score chain: holds one row entry, takes its neighbour's on shift.
module mhae_cell
    import mhae_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_d;
        end
    end

    assign o_q = r_val;
endmodule

[rtl/mhae_div.sv]
// Restoring divider, one quotient bit per cycle.
module mhae_div
    import mhae_pkg::*;
#(
    parameter int NUM_W = 33,
    parameter int DEN_W = 23
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_quot[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[rtl/multi_head_attention_engine_unit.sv]
// Top level of the multi-head scaled dot-product attention engine.
// A load item writes one query, key and value element.
// A read item computes the scores, softmax and weights, and for an output
// row also the weighted sums of the values: one shared multiply-accumulate
// unit walks the stores one element a cycle, a bit-serial divider yields
// one weight at a time, and the softmax row rotates through a chain of cells.
// Store entries read before they were loaded return undefined data.
module multi_head_attention_engine_unit
    import mhae_pkg::*;
#(
    parameter int TOKEN_COUNT = TOKEN_COUNT_DEF,
    parameter int HEAD_COUNT  = HEAD_COUNT_DEF,
    parameter int HEAD_WIDTH  = HEAD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mhae_item_if.sink   i_item,
    mhae_result_if.source o_result
);
    localparam int TJ_W  = TOKEN_COUNT > 1 ? $clog2(TOKEN_COUNT) : 1;
    localparam int H_W   = HEAD_COUNT > 1 ? $clog2(HEAD_COUNT) : 1;
    localparam int D_W   = HEAD_WIDTH > 1 ? $clog2(HEAD_WIDTH) : 1;
    localparam int DEPTH = TOKEN_COUNT * HEAD_COUNT * HEAD_WIDTH;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int WCNT  = TOKEN_COUNT < RESULT_LIMIT ? TOKEN_COUNT : RESULT_LIMIT;
    localparam int OCNT  = HEAD_WIDTH < RESULT_LIMIT ? HEAD_WIDTH : RESULT_LIMIT;
    localparam int ACC_W = 35 + $clog2(TOKEN_COUNT + HEAD_WIDTH);
    localparam int SP_W  = ACC_W + 18;
    localparam int SUM_W = 17 + $clog2(TOKEN_COUNT);
    localparam int NUM_W = 33;
    localparam logic [63:0] SCALE_ARG = (64'd1 << 34) / HEAD_WIDTH;
    localparam logic [63:0] SCALE_RAW = (isqrt64(SCALE_ARG) + 64'd1) >> 1;
    localparam logic [16:0] SCALE     = SCALE_RAW[16:0];
    localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
    localparam logic signed [SP_W-1:0]  HALF28   = SP_W'(1) << 27;
    localparam logic signed [SP_W-1:0]  S32MAX   = SP_W'(32'sh7FFFFFFF);
    localparam logic signed [SP_W-1:0]  S32MIN   = SP_W'($signed(32'h80000000));
    localparam logic signed [ACC_W-1:0] HALF16   = ACC_W'(1) << 15;
    localparam logic signed [ACC_W-1:0] S16MAX   = ACC_W'(16'sh7FFF);
    localparam logic signed [ACC_W-1:0] S16MIN   = ACC_W'($signed(16'h8000));

    function automatic logic [AW-1:0] addr_of(input logic [TJ_W-1:0] t,
                                              input logic [H_W-1:0] h,
                                              input logic [D_W-1:0] d);
        return AW'((32'(t) * HEAD_COUNT + 32'(h)) * HEAD_WIDTH + 32'(d));
    endfunction

    logic signed [DATA_W-1:0] q_mem [DEPTH];
    logic signed [DATA_W-1:0] k_mem [DEPTH];
    logic signed [DATA_W-1:0] v_mem [DEPTH];

    t_state r_state, n_state;
    t_ctl   ctl;
    t_op    r_op;
    logic [TJ_W-1:0] r_tok, r_j, r_cnt;
    logic [H_W-1:0]  r_head;
    logic [D_W-1:0]  r_d;
    logic            r_issue_done;

    logic signed [DATA_W-1:0] r_q_rd, r_k_rd, r_v_rd;
    logic [15:0]              r_w1;
    t_tap                     tap0, r_tap1, r_tap2;
    logic signed [33:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc, r_dot;
    logic                     r_dot_v, r_sv;
    logic signed [SP_W-1:0]   r_sprod;
    logic signed [31:0]       r_max;
    logic [SUM_W-1:0]         r_sum;
    logic [33:0]              r_y;
    logic [16:0]              r_m;
    logic [4:0]               r_n;
    logic                     r_big;

    logic             r_ov;
    t_kind            r_o_kind;
    logic [POS_W-1:0] r_o_pos;
    logic signed [DATA_W-1:0] r_o_out;
    logic [DATA_W-1:0] r_o_wgt;
    logic             r_o_last;

    logic [31:0] chain_q [TOKEN_COUNT];
    logic [31:0] head_in;
    logic [31:0] tail;

    logic accept, is_load, load_ok, read_ok, out_free;
    logic [AW-1:0] wr_addr, q_addr, kv_addr;
    logic signed [31:0] qk;
    logic signed [32:0] wv;
    logic signed [ACC_W-1:0] acc_n;
    logic signed [SP_W-1:0]  sr;
    logic signed [31:0]      score_sat;
    logic [32:0]  xdiff;
    logic [49:0]  yx;
    logic [21:0]  n_big;
    logic [16:0]  t0, t1, diff;
    logic [24:0]  lerp;
    logic [16:0]  e17;
    logic [17:0]  e_round;
    logic         div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [15:0]  w16;
    logic signed [ACC_W-1:0] orr;
    logic signed [DATA_W-1:0] osat;
    logic j_last, d_last;

    // Score chain
    assign tail = chain_q[TOKEN_COUNT-1];
    for (genvar g = 0; g < TOKEN_COUNT; g++) begin : g_chain
        mhae_cell #(.WIDTH(32)) u_cell (
            .i_clk  (i_clk),
            .i_shift(ctl.chain_shift),
            .i_d    (g == 0 ? head_in : chain_q[(g == 0) ? 0 : g - 1]),
            .o_q    (chain_q[g])
        );
    end

    mhae_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(ctl.div_start),
        .i_num  (div_num),
        .i_den  (r_sum),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    assign accept  = i_item.valid && ctl.in_ready;
    assign is_load = t_op'(i_item.operation) == OP_LOAD;
    assign load_ok = 32'(i_item.token_index) < TOKEN_COUNT
                  && 32'(i_item.head_index) < HEAD_COUNT
                  && 32'(i_item.dim_index) < HEAD_WIDTH;
    assign read_ok = (t_op'(i_item.operation) == OP_READ_OUT
                   || t_op'(i_item.operation) == OP_READ_WEIGHT)
                  && 32'(i_item.token_index) < TOKEN_COUNT
                  && 32'(i_item.head_index) < HEAD_COUNT;
    assign out_free = !r_ov || o_result.ready;
    assign j_last   = r_j == TJ_W'(TOKEN_COUNT - 1);
    assign d_last   = r_d == D_W'(HEAD_WIDTH - 1);

    assign wr_addr = addr_of(TJ_W'(i_item.token_index), H_W'(i_item.head_index),
                             D_W'(i_item.dim_index));
    assign q_addr  = addr_of(r_tok, r_head, r_d);
    assign kv_addr = addr_of(r_j, r_head, r_d);

    always_ff @(posedge i_clk) begin
        if (accept && is_load && load_ok) begin
            q_mem[wr_addr] <= i_item.q_value;
            k_mem[wr_addr] <= i_item.k_value;
            v_mem[wr_addr] <= i_item.v_value;
        end
        r_q_rd <= q_mem[q_addr];
        r_k_rd <= k_mem[kv_addr];
        r_v_rd <= v_mem[kv_addr];
    end

    // Datapath arithmetic
    assign qk    = r_q_rd * r_k_rd;
    assign wv    = $signed({1'b0, r_w1}) * r_v_rd;
    assign acc_n = (r_tap2.first ? ACC_ZERO : r_acc) + ACC_W'(r_prod);
    assign sr    = (r_sprod + HALF28) >>> 28;
    assign score_sat = sr > S32MAX ? 32'sh7FFFFFFF :
                       sr < S32MIN ? $signed(32'h80000000) : 32'(sr);
    assign xdiff = {r_max[31], r_max} - {tail[31], tail};
    assign yx    = 50'(xdiff) * 50'(LOG2E_Q16) + 50'd32768;
    assign n_big = r_y[33:12];
    assign t0    = pow2_entry({1'b0, r_y[11:8]});
    assign t1    = pow2_entry({1'b0, r_y[11:8]} + 5'd1);
    assign diff  = t0 - t1;
    assign lerp  = 25'(diff) * 25'(r_y[7:0]) + 25'd128;
    assign e_round = ({1'b0, r_m} + (18'(1) << (r_n - 5'd1))) >> r_n;
    assign e17   = r_big ? 17'd0 : (r_n == 5'd0 ? r_m : e_round[16:0]);
    assign div_num = {tail[16:0], 16'b0} + NUM_W'(r_sum >> 1);
    assign w16   = (|div_quot[NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];
    assign orr   = (r_dot + HALF16) >>> 16;
    assign osat  = orr > S16MAX ? 16'sh7FFF :
                   orr < S16MIN ? $signed(16'h8000) : 16'(orr);

    always_comb begin
        case (ctl.chain_sel)
            SEL_SCORE:  head_in = score_sat;
            SEL_EXP:    head_in = 32'(e17);
            SEL_WEIGHT: head_in = 32'(w16);
            default:    head_in = tail;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && read_ok) n_state = S_SCORE;
            S_SCORE: if (r_sv && r_cnt == TJ_W'(TOKEN_COUNT - 1)) n_state = S_MAX;
            S_MAX:   if (j_last) n_state = S_EXP_A;
            S_EXP_A: n_state = S_EXP_B;
            S_EXP_B: n_state = S_EXP_C;
            S_EXP_C: n_state = j_last ? S_DIV_S : S_EXP_A;
            S_DIV_S: n_state = S_DIV_W;
            S_DIV_W: begin
                if (div_done) begin
                    if (!j_last) n_state = S_DIV_S;
                    else if (r_op == OP_READ_OUT) n_state = S_OMAC;
                    else n_state = S_WOUT;
                end
            end
            S_WOUT:  if (out_free && r_j == TJ_W'(WCNT - 1)) n_state = S_IDLE;
            S_OMAC:  if (r_dot_v) n_state = S_OEMIT;
            S_OEMIT: begin
                if (out_free) n_state = (r_d == D_W'(OCNT - 1)) ? S_IDLE : S_OMAC;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        ctl = '{in_ready: 1'b0, issue: 1'b0, chain_shift: 1'b0,
                chain_sel: SEL_RECIRC, div_start: 1'b0, emit: 1'b0};
        tap0 = '{valid: 1'b0, first: 1'b0, last: 1'b0};
        unique case (r_state)
            S_IDLE:  ctl.in_ready = 1'b1;
            S_SCORE: begin
                ctl.issue       = !r_issue_done;
                ctl.chain_shift = r_sv;
                ctl.chain_sel   = SEL_SCORE;
                tap0 = '{valid: !r_issue_done, first: r_d == '0, last: d_last};
            end
            S_MAX:   ctl.chain_shift = 1'b1;
            S_EXP_C: begin
                ctl.chain_shift = 1'b1;
                ctl.chain_sel   = SEL_EXP;
            end
            S_DIV_S: ctl.div_start = 1'b1;
            S_DIV_W: begin
                ctl.chain_shift = div_done;
                ctl.chain_sel   = SEL_WEIGHT;
            end
            S_WOUT: begin
                ctl.emit        = out_free;
                ctl.chain_shift = out_free;
            end
            S_OMAC: begin
                ctl.issue       = !r_issue_done;
                ctl.chain_shift = !r_issue_done;
                tap0 = '{valid: !r_issue_done, first: r_j == '0, last: j_last};
            end
            S_OEMIT: ctl.emit = out_free;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_j          <= '0;
            r_d          <= '0;
            r_cnt        <= '0;
            r_issue_done <= 1'b0;
            r_tap1       <= '0;
            r_tap2       <= '0;
            r_dot_v      <= 1'b0;
            r_sv         <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap1  <= tap0;
            r_tap2  <= r_tap1;
            r_dot_v <= r_tap2.valid && r_tap2.last;
            r_sv    <= r_dot_v && r_state == S_SCORE;
            if (ctl.emit) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_j          <= '0;
                    r_d          <= '0;
                    r_cnt        <= '0;
                    r_issue_done <= 1'b0;
                end
                S_SCORE: begin
                    if (ctl.issue) begin
                        if (d_last) begin
                            r_d <= '0;
                            if (j_last) begin
                                r_j          <= '0;
                                r_issue_done <= 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end else begin
                            r_d <= r_d + 1'b1;
                        end
                    end
                    if (r_sv) r_cnt <= r_cnt + 1'b1;
                end
                S_MAX, S_EXP_C: r_j <= j_last ? '0 : r_j + 1'b1;
                S_DIV_W: begin
                    if (div_done) begin
                        r_j <= j_last ? '0 : r_j + 1'b1;
                        if (j_last) begin
                            r_issue_done <= 1'b0;
                            r_d          <= '0;
                        end
                    end
                end
                S_WOUT: if (ctl.emit) r_j <= r_j + 1'b1;
                S_OMAC: begin
                    if (ctl.issue) begin
                        if (j_last) begin
                            r_j          <= '0;
                            r_issue_done <= 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_OEMIT: begin
                    if (ctl.emit) begin
                        r_d          <= r_d + 1'b1;
                        r_issue_done <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && read_ok) begin
            r_op   <= t_op'(i_item.operation);
            r_tok  <= TJ_W'(i_item.token_index);
            r_head <= H_W'(i_item.head_index);
        end
        r_w1   <= tail[15:0];
        r_prod <= (r_state == S_SCORE) ? 34'(qk) : 34'(wv);
        if (r_tap2.valid) begin
            r_acc <= acc_n;
            if (r_tap2.last) r_dot <= acc_n;
        end
        r_sprod <= r_dot * $signed({1'b0, SCALE});
        if (r_state == S_MAX) begin
            r_max <= (r_j == '0 || $signed(tail) > r_max) ? $signed(tail) : r_max;
            r_sum <= '0;
        end
        if (r_state == S_EXP_A) r_y <= 34'(yx >> 16);
        if (r_state == S_EXP_B) begin
            r_m   <= t0 - 17'(lerp >> 8);
            r_n   <= n_big[4:0];
            r_big <= n_big >= 22'd17;
        end
        if (r_state == S_EXP_C) r_sum <= r_sum + SUM_W'(e17);
        if (ctl.emit) begin
            if (r_state == S_WOUT) begin
                r_o_kind <= KIND_WEIGHT;
                r_o_pos  <= POS_W'(r_j);
                r_o_out  <= '0;
                r_o_wgt  <= tail[15:0];
                r_o_last <= r_j == TJ_W'(WCNT - 1);
            end else begin
                r_o_kind <= KIND_OUT;
                r_o_pos  <= POS_W'(r_d);
                r_o_out  <= osat;
                r_o_wgt  <= '0;
                r_o_last <= r_d == D_W'(OCNT - 1);
            end
        end
    end

    assign i_item.ready          = ctl.in_ready;
    assign o_result.valid        = r_ov;
    assign o_result.result_kind  = r_o_kind;
    assign o_result.position     = r_o_pos;
    assign o_result.out_value    = r_o_out;
    assign o_result.weight_value = r_o_wgt;
    assign o_result.last_flag    = r_o_last;
endmodule
